>>> rtl/zhhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zhhp_pkg;

    localparam logic [7:0]  PAD_CHAR   = 8'h2A;
    localparam logic [7:0]  ZDLE_CHAR  = 8'h18;
    localparam logic [7:0]  HEX_MARK   = 8'h42;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [3:0]  LAST_DIGIT = 4'd13;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_BAD_HEX = 2'd2;

    // byte index inside the hex body (pairs of digits)
    localparam logic [2:0] IDX_TYPE   = 3'd0;
    localparam logic [2:0] IDX_ARG0   = 3'd1;
    localparam logic [2:0] IDX_ARG1   = 3'd2;
    localparam logic [2:0] IDX_ARG2   = 3'd3;
    localparam logic [2:0] IDX_ARG3   = 3'd4;
    localparam logic [2:0] IDX_CRC_HI = 3'd5;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_PAD    = 4'b0010,
        PH_ZDLE   = 4'b0100,
        PH_DIGITS = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] header_arg;
        logic [7:0]  frame_type;
    } t_result;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/zmodem_hex_header_parser_top.sv
// ZMODEM hex header receiver.
// Slave stream: one received serial byte per item in tdata[7:0].
// Master stream: one item per finished header: frame type, 32-bit argument
// (first received argument byte least significant) and a 2-bit status
// (0 ok, 1 CRC mismatch, 2 non-hex digit; type and argument are zero then).
// Bytes outside a header (line trailer, XON, noise) give no item.
// Data path: input register -> hex decode, byte-wise CRC-16 and header
// state update -> result register. A byte that completes or breaks a
// header waits in the input register; its result is captured in the
// result register when that byte moves on into the parser.
// Throughput is one byte per cycle while the master side does not stall;
// the single-pass CRC step per byte sets the critical path.
// When the master side stalls, the result register holds its item and
// the input register still takes one more byte; tready then drops until
// the result is taken. No byte moves on while a result waits.
// Synchronous active-low reset empties both registers and returns the
// parser to hunting for the pad character.
`timescale 1ns / 1ps
`default_nettype none

module zmodem_hex_header_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata    // [7:0] frame_type, [39:8] header_arg,
                                               // [41:40] status, [47:42] zero
);

    logic              advance;
    logic              in_valid;
    logic [7:0]        in_byte;
    logic              fire;
    logic              res_valid;
    zhhp_pkg::t_result res;
    zhhp_pkg::t_result out_res;

    assign advance = !o_m_axis_tvalid || i_m_axis_tready;
    assign fire    = in_valid && advance;

    zhhp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    zhhp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    zhhp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_valid     (o_m_axis_tvalid),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata = {6'd0, out_res.status, out_res.header_arg, out_res.frame_type};

endmodule

`default_nettype wire

>>> rtl/zhhp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module zhhp_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // slot frees up when its item moves on into the parser
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

>>> rtl/zhhp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module zhhp_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output zhhp_pkg::t_result o_res
);

    zhhp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_count, n_count;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_arg, n_arg;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rx_crc, n_rx_crc;

    zhhp_pkg::t_hex hex;
    logic [7:0]     dbyte;
    logic [2:0]     idx;
    logic [15:0]    crc_upd;

    always_comb begin
        hex     = zhhp_pkg::hex_value(i_byte);
        dbyte   = {r_high, hex.val};
        idx     = r_count[3:1];
        crc_upd = zhhp_pkg::crc_byte(r_crc, dbyte);

        n_phase  = r_phase;
        n_count  = r_count;
        n_high   = r_high;
        n_type   = r_type;
        n_arg    = r_arg;
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (r_phase != zhhp_pkg::PH_DIGITS) begin
            if (i_byte == zhhp_pkg::PAD_CHAR) begin
                n_phase = zhhp_pkg::PH_PAD;
            end else if (r_phase == zhhp_pkg::PH_PAD && i_byte == zhhp_pkg::ZDLE_CHAR) begin
                n_phase = zhhp_pkg::PH_ZDLE;
            end else if (r_phase == zhhp_pkg::PH_ZDLE && i_byte == zhhp_pkg::HEX_MARK) begin
                n_phase  = zhhp_pkg::PH_DIGITS;
                n_count  = '0;
                n_high   = '0;
                n_type   = '0;
                n_arg    = '0;
                n_crc    = '0;
                n_rx_crc = '0;
            end else begin
                n_phase = zhhp_pkg::PH_HUNT;
            end
        end else if (!hex.ok) begin
            // bad digit ends the header; a pad here starts the next one
            n_phase = (i_byte == zhhp_pkg::PAD_CHAR) ? zhhp_pkg::PH_PAD : zhhp_pkg::PH_HUNT;
            n_count = '0;
            o_res_valid   = 1'b1;
            o_res.status  = zhhp_pkg::ST_BAD_HEX;
        end else if (!r_count[0]) begin
            n_high  = hex.val;
            n_count = r_count + 4'd1;
        end else begin
            unique case (idx)
                zhhp_pkg::IDX_TYPE: begin
                    n_type = dbyte;
                    n_crc  = crc_upd;
                end
                zhhp_pkg::IDX_ARG0: begin
                    n_arg[7:0] = r_arg[7:0] | dbyte;
                    n_crc      = crc_upd;
                end
                zhhp_pkg::IDX_ARG1: begin
                    n_arg[15:8] = r_arg[15:8] | dbyte;
                    n_crc       = crc_upd;
                end
                zhhp_pkg::IDX_ARG2: begin
                    n_arg[23:16] = r_arg[23:16] | dbyte;
                    n_crc        = crc_upd;
                end
                zhhp_pkg::IDX_ARG3: begin
                    n_arg[31:24] = r_arg[31:24] | dbyte;
                    n_crc        = crc_upd;
                end
                zhhp_pkg::IDX_CRC_HI: begin
                    n_rx_crc = {dbyte, 8'h00};
                end
                default: begin
                    n_rx_crc = r_rx_crc | {8'h00, dbyte};
                end
            endcase

            if (r_count >= zhhp_pkg::LAST_DIGIT) begin
                n_phase = zhhp_pkg::PH_HUNT;
                n_count = '0;
                o_res_valid      = 1'b1;
                o_res.frame_type = n_type;
                o_res.header_arg = n_arg;
                o_res.status     = (n_rx_crc == n_crc) ? zhhp_pkg::ST_OK
                                                       : zhhp_pkg::ST_CRC_ERR;
            end else begin
                n_count = r_count + 4'd1;
            end
        end

        if (!i_fire) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= zhhp_pkg::PH_HUNT;
            r_count <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_high   <= n_high;
            r_type   <= n_type;
            r_arg    <= n_arg;
            r_crc    <= n_crc;
            r_rx_crc <= n_rx_crc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/zhhp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module zhhp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic              i_res_valid,
    input  wire zhhp_pkg::t_result i_res,
    output logic                   o_valid,
    output zhhp_pkg::t_result      o_res
);

    logic              r_valid;
    zhhp_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire
